// ----- src/frustum_sphere_cull_assert.svh -----
// assertion macros used by the frustum sphere cull top level
`ifndef FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define FSC_ASSERT_SAME(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define FSC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- src/fsc_pkg.sv -----
// types, widths and plane extraction for the frustum sphere cull block
`default_nettype none

package fsc_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 15;
    localparam int ENTRY_WIDTH  = 16;
    localparam int NUM_ROWS     = 4;
    localparam int ROW_WIDTH    = 4 * ENTRY_WIDTH;
    localparam int NUM_PLANES   = 6;
    localparam int RAW_SHIFT    = 12;
    localparam int PIPE_DEPTH   = 6;

    localparam int CFG_W     = ROW_WIDTH;
    localparam int CFG_IDX_W = 3;

    // plane component, product and distance widths
    localparam int PC_W   = ENTRY_WIDTH + 1;
    localparam int PROD_W = PC_W + COORD_WIDTH;
    localparam int D_W    = PROD_W + 2;
    localparam int MAG_W  = D_W - 1;
    localparam int MLO_W  = MAG_W / 2;
    localparam int MHI_W  = MAG_W - MLO_W;
    localparam int D2_W   = 2 * MAG_W;

    // normal length squared and radius squared widths
    localparam int SQ_W  = 2 * PC_W - 1;
    localparam int N2_W  = 2 * PC_W;
    localparam int NLO_W = N2_W / 2;
    localparam int NHI_W = N2_W - NLO_W;
    localparam int R2_W  = 2 * RADIUS_WIDTH;
    localparam int RN_W  = R2_W + N2_W;
    localparam int CMP_W = (D2_W > RN_W) ? D2_W : RN_W;

    localparam int RS_W  = RADIUS_WIDTH + RAW_SHIFT;
    localparam int RAW_W = ((D_W > RS_W) ? D_W : RS_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 3'd0,
        REG_ROW1 = 3'd1,
        REG_ROW2 = 3'd2,
        REG_ROW3 = 3'd3,
        REG_NORM = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PLANE_LEFT,
        PLANE_RIGHT,
        PLANE_TOP,
        PLANE_BOTTOM,
        PLANE_NEAR,
        PLANE_FAR
    } plane_t;

    localparam plane_t PLANE_ORDER [NUM_PLANES] = '{
        PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM, PLANE_NEAR, PLANE_FAR
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic [RADIUS_WIDTH-1:0]       radius;
    } sphere_t;

    typedef struct packed {
        logic point_inside;
        logic intersects;
        logic envelops;
    } result_t;

    // signed plane distance and the terms the radius tests need
    typedef struct packed {
        logic signed [D_W-1:0]   dval;
        logic [N2_W-1:0]         n2;
        logic [R2_W-1:0]         r2;
        logic [RADIUS_WIDTH-1:0] radius;
        logic                    norm;
    } dist_t;

    // per-plane failures of the three tests
    typedef struct packed {
        logic d_neg;
        logic inter_fail;
        logic env_fail;
    } fail_t;

    function automatic logic signed [PC_W-1:0] plane_comp(
        input plane_t p,
        input logic [ROW_WIDTH-1:0] row
    );
        logic signed [PC_W-1:0] c0;
        logic signed [PC_W-1:0] c1;
        logic signed [PC_W-1:0] c2;
        logic signed [PC_W-1:0] c3;
        c0 = PC_W'($signed(row[0*ENTRY_WIDTH +: ENTRY_WIDTH]));
        c1 = PC_W'($signed(row[1*ENTRY_WIDTH +: ENTRY_WIDTH]));
        c2 = PC_W'($signed(row[2*ENTRY_WIDTH +: ENTRY_WIDTH]));
        c3 = PC_W'($signed(row[3*ENTRY_WIDTH +: ENTRY_WIDTH]));
        case (p)
            PLANE_LEFT:   plane_comp = c3 + c0;
            PLANE_RIGHT:  plane_comp = c3 - c0;
            PLANE_TOP:    plane_comp = c3 - c1;
            PLANE_BOTTOM: plane_comp = c3 + c1;
            PLANE_NEAR:   plane_comp = c2;
            default:      plane_comp = c3 - c2;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- src/fsc_dist.sv -----
// plane extraction, products and plane distance for one plane (two stages)
`default_nettype none

module fsc_dist (
    input  logic                                           clk,
    input  logic                                           adv,
    input  fsc_pkg::plane_t                                plane,
    input  logic [fsc_pkg::NUM_ROWS-1:0][fsc_pkg::ROW_WIDTH-1:0] rows,
    input  fsc_pkg::sphere_t                               sph,
    input  logic                                           norm,
    output fsc_pkg::dist_t                                 plane_d
);
    import fsc_pkg::*;

    logic signed [PC_W-1:0]     pa;
    logic signed [PC_W-1:0]     pb;
    logic signed [PC_W-1:0]     pc;
    logic signed [PC_W-1:0]     pd;
    logic signed [2*PC_W-1:0]   sqa_full;
    logic signed [2*PC_W-1:0]   sqb_full;
    logic signed [2*PC_W-1:0]   sqc_full;

    logic signed [PROD_W-1:0]   px_next, px_reg;
    logic signed [PROD_W-1:0]   py_next, py_reg;
    logic signed [PROD_W-1:0]   pz_next, pz_reg;
    logic signed [PC_W-1:0]     d_reg;
    logic [SQ_W-1:0]            sqa_reg, sqb_reg, sqc_reg;
    logic [R2_W-1:0]            r2_next, r2_reg;
    logic [RADIUS_WIDTH-1:0]    rad_reg;
    logic                       norm_reg;

    dist_t                      dist_next, dist_reg;

    // stage a: plane coefficients, center products, squares
    always_comb
    begin
        pa = plane_comp(plane, rows[0]);
        pb = plane_comp(plane, rows[1]);
        pc = plane_comp(plane, rows[2]);
        pd = plane_comp(plane, rows[3]);
        px_next  = PROD_W'(pa) * PROD_W'($signed(sph.center_x));
        py_next  = PROD_W'(pb) * PROD_W'($signed(sph.center_y));
        pz_next  = PROD_W'(pc) * PROD_W'($signed(sph.center_z));
        sqa_full = (2*PC_W)'(pa) * (2*PC_W)'(pa);
        sqb_full = (2*PC_W)'(pb) * (2*PC_W)'(pb);
        sqc_full = (2*PC_W)'(pc) * (2*PC_W)'(pc);
        r2_next  = R2_W'(sph.radius) * R2_W'(sph.radius);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            d_reg    <= pd;
            sqa_reg  <= sqa_full[SQ_W-1:0];
            sqb_reg  <= sqb_full[SQ_W-1:0];
            sqc_reg  <= sqc_full[SQ_W-1:0];
            r2_reg   <= r2_next;
            rad_reg  <= sph.radius;
            norm_reg <= norm;
        end
    end

    // stage b: distance sum and normal length squared
    always_comb
    begin
        dist_next.dval   = D_W'(px_reg) + D_W'(py_reg) + D_W'(pz_reg) + D_W'(d_reg);
        dist_next.n2     = N2_W'(sqa_reg) + N2_W'(sqb_reg) + N2_W'(sqc_reg);
        dist_next.r2     = r2_reg;
        dist_next.radius = rad_reg;
        dist_next.norm   = norm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign plane_d = dist_reg;

endmodule

`default_nettype wire

// ----- src/fsc_cmp.sv -----
// squared-distance and radius tests for one plane (two stages)
`default_nettype none

module fsc_cmp (
    input  logic            clk,
    input  logic            adv,
    input  fsc_pkg::dist_t  plane_d,
    output fsc_pkg::fail_t  fail
);
    import fsc_pkg::*;

    logic                       neg;
    logic signed [D_W-1:0]      absd;
    logic [MAG_W-1:0]           mag;
    logic [MHI_W-1:0]           mh;
    logic [MLO_W-1:0]           ml;
    logic [NHI_W-1:0]           nh;
    logic [NLO_W-1:0]           nl;
    logic signed [RAW_W-1:0]    dext;
    logic signed [RAW_W-1:0]    rs;
    logic signed [RAW_W-1:0]    raw_sum;
    logic signed [RAW_W-1:0]    raw_diff;

    logic [2*MHI_W-1:0]         hh_next, hh_reg;
    logic [MHI_W+MLO_W-1:0]     hl_next, hl_reg;
    logic [2*MLO_W-1:0]         ll_next, ll_reg;
    logic [R2_W+NHI_W-1:0]      rnh_next, rnh_reg;
    logic [R2_W+NLO_W-1:0]      rnl_next, rnl_reg;
    logic                       neg_c_reg, raw_i_c_reg, raw_e_c_reg, norm_c_reg;

    logic [CMP_W-1:0]           d2_next, d2_reg;
    logic [CMP_W-1:0]           rn_next, rn_reg;
    logic                       neg_d_reg, raw_i_d_reg, raw_e_d_reg, norm_d_reg;

    // stage c: magnitude split into halves for the partial products
    always_comb
    begin
        neg      = plane_d.dval[D_W-1];
        absd     = neg ? -plane_d.dval : plane_d.dval;
        mag      = absd[MAG_W-1:0];
        mh       = mag[MAG_W-1:MLO_W];
        ml       = mag[MLO_W-1:0];
        nh       = plane_d.n2[N2_W-1:NLO_W];
        nl       = plane_d.n2[NLO_W-1:0];
        hh_next  = (2*MHI_W)'(mh) * (2*MHI_W)'(mh);
        hl_next  = (MHI_W+MLO_W)'(mh) * (MHI_W+MLO_W)'(ml);
        ll_next  = (2*MLO_W)'(ml) * (2*MLO_W)'(ml);
        rnh_next = (R2_W+NHI_W)'(plane_d.r2) * (R2_W+NHI_W)'(nh);
        rnl_next = (R2_W+NLO_W)'(plane_d.r2) * (R2_W+NLO_W)'(nl);
        // raw mode scales the radius to the q.12 distance units
        dext     = RAW_W'(plane_d.dval);
        rs       = $signed(RAW_W'(plane_d.radius)) <<< RAW_SHIFT;
        raw_sum  = dext + rs;
        raw_diff = dext - rs;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh_reg      <= hh_next;
            hl_reg      <= hl_next;
            ll_reg      <= ll_next;
            rnh_reg     <= rnh_next;
            rnl_reg     <= rnl_next;
            neg_c_reg   <= neg;
            raw_i_c_reg <= raw_sum[RAW_W-1];
            raw_e_c_reg <= raw_diff[RAW_W-1];
            norm_c_reg  <= plane_d.norm;
        end
    end

    // stage d: recombine partials into full squares
    always_comb
    begin
        d2_next = (CMP_W'(hh_reg) << (2*MLO_W)) + (CMP_W'(hl_reg) << (MLO_W+1))
                + CMP_W'(ll_reg);
        rn_next = (CMP_W'(rnh_reg) << NLO_W) + CMP_W'(rnl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg      <= d2_next;
            rn_reg      <= rn_next;
            neg_d_reg   <= neg_c_reg;
            raw_i_d_reg <= raw_i_c_reg;
            raw_e_d_reg <= raw_e_c_reg;
            norm_d_reg  <= norm_c_reg;
        end
    end

    // d + r|n| < 0 iff d < 0 and d^2 > r^2 n2; d - r|n| < 0 iff d < 0 or d^2 < r^2 n2
    always_comb
    begin
        fail.d_neg      = neg_d_reg;
        fail.inter_fail = norm_d_reg ? (neg_d_reg && (d2_reg > rn_reg)) : raw_i_d_reg;
        fail.env_fail   = norm_d_reg ? (neg_d_reg || (d2_reg < rn_reg)) : raw_e_d_reg;
    end

endmodule

`default_nettype wire

// ----- src/frustum_sphere_cull.sv -----
// top level of the frustum sphere cull block
//
//  channel   dir   handshake                    payload
//  sphere    in    sphere_valid/sphere_ready    sphere_t: center xyz, radius
//  result    out   result_valid/result_ready    result_t: inside, intersects, envelops
//  cfg       in    cfg_we                       cfg_index, cfg_data
//
// one item per cycle while the result side does not stall; an accepted item passes
// through six register stages (input, two distance stages, two squared-compare
// stages, output) before its result is offered
// a stalled result freezes the whole pipeline; nothing moves and nothing is lost
// reset clears valid bits, matrix rows to zero and normalize mode to one
`default_nettype none
`include "frustum_sphere_cull_assert.svh"

module frustum_sphere_cull (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sphere_valid,
    output logic                           sphere_ready,
    input  fsc_pkg::sphere_t               sphere,
    output logic                           result_valid,
    input  logic                           result_ready,
    output fsc_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsc_pkg::CFG_W-1:0]      cfg_data
);
    import fsc_pkg::*;

    logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] row_reg;
    logic                               norm_reg;
    logic [PIPE_DEPTH-1:0]              vld_reg, vld_next;
    logic                               adv;
    sphere_t                            in_reg;
    dist_t                              lane_dist [NUM_PLANES];
    fail_t                              lane_fail [NUM_PLANES];
    result_t                            result_next, result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            norm_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                REG_NORM: norm_reg   <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // the pipeline moves as a whole unless the output item waits
    assign adv          = !vld_reg[PIPE_DEPTH-1] || result_ready;
    assign sphere_ready = adv;
    assign vld_next     = {vld_reg[PIPE_DEPTH-2:0], sphere_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= sphere;
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_plane
        fsc_dist u_dist (
            .clk     (clk),
            .adv     (adv),
            .plane   (PLANE_ORDER[g]),
            .rows    (row_reg),
            .sph     (in_reg),
            .norm    (norm_reg),
            .plane_d (lane_dist[g])
        );

        fsc_cmp u_cmp (
            .clk     (clk),
            .adv     (adv),
            .plane_d (lane_dist[g]),
            .fail    (lane_fail[g])
        );
    end

    always_comb
    begin
        result_next = '{point_inside: 1'b1, intersects: 1'b1, envelops: 1'b1};
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (lane_fail[i].d_neg)
            begin
                result_next.point_inside = 1'b0;
            end
            if (lane_fail[i].inter_fail)
            begin
                result_next.intersects = 1'b0;
            end
            if (lane_fail[i].env_fail)
            begin
                result_next.envelops = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = vld_reg[PIPE_DEPTH-1];
    assign result       = result_reg;

    `FSC_ASSERT_NEXT(a_vld_shift, adv, vld_reg[PIPE_DEPTH-1:1] == $past(vld_reg[PIPE_DEPTH-2:0]), "valid bits did not follow their items")
    `FSC_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_reg) && $stable(result_reg), "pipeline moved during a stall")
    `FSC_ASSERT_SAME(a_test_order, result_valid && result.envelops, result.point_inside && result.intersects, "envelops without inside and intersects")

endmodule

`default_nettype wire

// ----- tb/sv/frustum_sphere_cull_tb.sv -----
// self-checking testbench for the frustum sphere cull block
`timescale 1ns / 100ps

module frustum_sphere_cull_tb;

    import fsc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 160;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum int {
        MTX_BOX,
        MTX_MIN,
        MTX_MAX,
        MTX_NOISE
    } matrix_kind_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        sphere_t               sph;
        bit                    known;
        result_t               known_verdict;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sphere_valid = 1'b0;
    logic                  sphere_ready;
    sphere_t               sphere_in = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_out;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // register copies the predictor works from
    logic [ROW_WIDTH-1:0]  shadow_row [NUM_ROWS] = '{default: '0};
    bit                    shadow_norm = 1'b1;

    result_t               pending_verdicts [$];
    directed_row_t         directed_rows [$];
    result_t               verdict_due;
    int                    verdicts_seen = 0;
    int                    mismatch_count = 0;
    int                    sent_total = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_left = 0;
    bit                    burst_done = 1'b0;
    int                    cycle_count = 0;

    frustum_sphere_cull uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sphere_valid (sphere_valid),
        .sphere_ready (sphere_ready),
        .sphere       (sphere_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // plane component k (a, b, c, d) taken from row k of the matrix
    function automatic longint plane_term(plane_t p, int k);
        longint c0;
        longint c1;
        longint c2;
        longint c3;
        c0 = $signed(shadow_row[k][0*ENTRY_WIDTH +: ENTRY_WIDTH]);
        c1 = $signed(shadow_row[k][1*ENTRY_WIDTH +: ENTRY_WIDTH]);
        c2 = $signed(shadow_row[k][2*ENTRY_WIDTH +: ENTRY_WIDTH]);
        c3 = $signed(shadow_row[k][3*ENTRY_WIDTH +: ENTRY_WIDTH]);
        case (p)
            PLANE_LEFT:   return c3 + c0;
            PLANE_RIGHT:  return c3 - c0;
            PLANE_TOP:    return c3 - c1;
            PLANE_BOTTOM: return c3 + c1;
            PLANE_NEAR:   return c2;
            default:      return c3 - c2;
        endcase
    endfunction

    function automatic result_t classify_sphere(sphere_t s);
        longint          x;
        longint          y;
        longint          z;
        longint          a;
        longint          b;
        longint          c;
        longint          d;
        longint          d_plane;
        longint          rs;
        longint unsigned r;
        longint unsigned n2;
        longint unsigned mag;
        logic [127:0]    d_sq;
        logic [127:0]    rn_sq;
        result_t         v;
        x = s.center_x;
        y = s.center_y;
        z = s.center_z;
        r = s.radius;
        v.point_inside = 1'b1;
        v.intersects = 1'b1;
        v.envelops = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            a = plane_term(plane_t'(i), 0);
            b = plane_term(plane_t'(i), 1);
            c = plane_term(plane_t'(i), 2);
            d = plane_term(plane_t'(i), 3);
            d_plane = a * x + b * y + c * z + d;
            if (d_plane < 0)
                v.point_inside = 1'b0;
            if (shadow_norm)
            begin
                // exact squared compare of |D| against r*|n|
                n2 = a * a + b * b + c * c;
                mag = (d_plane < 0) ? -d_plane : d_plane;
                d_sq = 128'(mag) * 128'(mag);
                rn_sq = 128'(r * r) * 128'(n2);
                if (d_plane < 0 && d_sq > rn_sq)
                    v.intersects = 1'b0;
                if (d_plane < 0 || d_sq < rn_sq)
                    v.envelops = 1'b0;
            end
            else
            begin
                rs = longint'(r) << RAW_SHIFT;
                if (d_plane + rs < 0)
                    v.intersects = 1'b0;
                if (d_plane - rs < 0)
                    v.envelops = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic sphere_t random_sphere(int span);
        sphere_t s;
        if (span == 0 || $urandom_range(0, 7) == 0)
        begin
            s.center_x = 16'($urandom);
            s.center_y = 16'($urandom);
            s.center_z = 16'($urandom);
            s.radius = 15'($urandom);
        end
        else
        begin
            s.center_x = 16'($urandom_range(0, 2 * span) - span);
            s.center_y = 16'($urandom_range(0, 2 * span) - span);
            s.center_z = 16'($urandom_range(0, 2 * span) - span);
            s.radius = 15'($urandom_range(0, span));
        end
        return s;
    endfunction

    function automatic void dir_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        directed_row_t row;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = value;
        row.sph = '0;
        row.known = 1'b0;
        row.known_verdict = '0;
        directed_rows.push_back(row);
    endfunction

    // verdict bits: point_inside, intersects, envelops
    function automatic void dir_sphere(int x, int y, int z, int r, bit known,
                                       logic [2:0] verdict);
        directed_row_t row;
        row.is_write = 1'b0;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.sph.center_x = 16'(x);
        row.sph.center_y = 16'(y);
        row.sph.center_z = 16'(z);
        row.sph.radius = 15'(r);
        row.known = known;
        row.known_verdict = verdict;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: shadow_row[idx[1:0]] = value;
            REG_NORM: shadow_norm = value[0];
            default: ;
        endcase
    endtask

    // stop offering and wait until every result is back
    task automatic drain_block();
        sphere_valid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic offer_sphere(input sphere_t s, input bit known, input result_t verdict);
        sphere_in <= s;
        sphere_valid <= 1'b1;
        do @(posedge clk); while (!sphere_ready);
        if (known)
            pending_verdicts.push_back(verdict);
        else
            pending_verdicts.push_back(classify_sphere(s));
        sent_total <= sent_total + 1;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            sphere_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // receiver: random stalls, plus one long hold-off that backs the pipeline up
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!burst_done && sent_total >= 400)
        begin
            burst_done <= 1'b1;
            hold_left <= 60;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
                flag_mismatch("result with no item pending");
            else
            begin
                verdict_due = pending_verdicts.pop_front();
                if (result_out.point_inside !== verdict_due.point_inside)
                    flag_mismatch($sformatf("result %0d point_inside %b, want %b",
                        verdicts_seen, result_out.point_inside, verdict_due.point_inside));
                if (result_out.intersects !== verdict_due.intersects)
                    flag_mismatch($sformatf("result %0d intersects %b, want %b",
                        verdicts_seen, result_out.intersects, verdict_due.intersects));
                if (result_out.envelops !== verdict_due.envelops)
                    flag_mismatch($sformatf("result %0d envelops %b, want %b",
                        verdicts_seen, result_out.envelops, verdict_due.envelops));
            end
            verdicts_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_verdicts.size());
            $display("** frustum_sphere_cull: FAILED **");
            $finish;
        end
    end

    initial
    begin
        bit                   cfg_open;
        bit                   norm_sel;
        matrix_kind_t         kind;
        logic [CFG_W-1:0]     mtx [NUM_ROWS];
        int                   diag [3];
        int                   span;
        int                   dmin;
        int                   w;

        // after reset every plane is zero, so any sphere passes all tests
        dir_sphere(0, 0, 0, 0, 1, 3'b111);
        dir_sphere(-32768, -32768, -32768, 32767, 1, 3'b111);
        dir_sphere(32767, 32767, 32767, 32767, 1, 3'b111);
        // unit box: x and y in [-1, 1], z in [0, 1], |n| = 1.0
        dir_write(REG_ROW0, 64'h0000_0000_0000_1000);
        dir_write(REG_ROW1, 64'h0000_0000_1000_0000);
        dir_write(REG_ROW2, 64'h0000_1000_0000_0000);
        dir_write(REG_ROW3, 64'h1000_0000_0000_0000);
        dir_sphere(0, 0, 0, 0, 1, 3'b111);
        dir_sphere(0, 0, 0, 1, 1, 3'b110);
        dir_sphere(1, 1, 1, 0, 1, 3'b111);
        dir_sphere(5, 0, 0, 0, 1, 3'b000);
        dir_sphere(3, 0, 0, 2, 1, 3'b010);   // touches the right plane
        dir_sphere(4, 0, 0, 2, 1, 3'b000);
        dir_sphere(-32768, 32767, -32768, 32767, 0, 3'b000);
        dir_write(REG_NORM, 64'h0);
        dir_sphere(3, 0, 0, 2, 1, 3'b010);
        dir_sphere(0, 0, 0, 1, 1, 3'b110);
        // x scale 2.0: raw and normalized modes now differ
        dir_write(REG_ROW0, 64'h0000_0000_0000_2000);
        dir_sphere(1, 0, 0, 1, 0, 3'b000);
        dir_sphere(2, 0, 0, 1, 0, 3'b000);
        dir_write(REG_NORM, 64'h1);
        dir_sphere(1, 0, 0, 1, 0, 3'b000);
        dir_write(REG_ROW0, 64'h8000_7fff_8000_7fff);
        dir_write(REG_ROW1, 64'h8000_7fff_8000_7fff);
        dir_write(REG_ROW2, 64'h8000_7fff_8000_7fff);
        dir_write(REG_ROW3, 64'h8000_7fff_8000_7fff);
        dir_sphere(32767, -32768, 32767, 32767, 0, 3'b000);
        dir_sphere(-32768, 32767, -32768, 0, 0, 3'b000);
        dir_write(REG_ROW0, 64'h7fff_7fff_7fff_7fff);
        dir_write(REG_ROW1, 64'h7fff_7fff_7fff_7fff);
        dir_write(REG_ROW2, 64'h7fff_7fff_7fff_7fff);
        dir_write(REG_ROW3, 64'h7fff_7fff_7fff_7fff);
        dir_sphere(-32768, -32768, -32768, 32767, 0, 3'b000);
        dir_sphere(32767, 32767, 32767, 0, 0, 3'b000);
        // zero normals with negative offsets: in normalized mode the radius cannot rescue the point test
        dir_write(REG_ROW0, 64'h0);
        dir_write(REG_ROW1, 64'h0);
        dir_write(REG_ROW2, 64'h0);
        dir_write(REG_ROW3, 64'hf000_f000_f000_f000);
        dir_sphere(0, 0, 0, 32767, 1, 3'b000);
        dir_write(REG_NORM, 64'h0);
        dir_sphere(0, 0, 0, 32767, 0, 3'b000);
        // upper data bits and unmapped indexes must not disturb anything
        dir_write(REG_NORM, 64'hffff_ffff_ffff_ffff);
        dir_write(REG_SPARE, 64'hffff_ffff_ffff_ffff);
        dir_write(REG_UNMAPPED, 64'hffff_ffff_ffff_ffff);
        dir_sphere(0, 0, 0, 32767, 0, 3'b000);
        dir_write(REG_NORM, 64'hffff_ffff_ffff_fffe);
        dir_sphere(0, 0, 0, 32767, 0, 3'b000);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct <= 27;
        recv_idle_pct <= 62;

        cfg_open = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                if (!cfg_open)
                begin
                    drain_block();
                    cfg_open = 1'b1;
                end
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                offer_sphere(directed_rows[i].sph, directed_rows[i].known,
                             directed_rows[i].known_verdict);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin kind = MTX_BOX;   norm_sel = 1'b1; end
                1: begin kind = MTX_MIN;   norm_sel = 1'b0; end
                2: begin kind = MTX_BOX;   norm_sel = 1'b0; end
                3: begin kind = MTX_NOISE; norm_sel = 1'b1; end
                4: begin kind = MTX_BOX;   norm_sel = 1'b1; end
                5: begin kind = MTX_MAX;   norm_sel = 1'b1; end
                6: begin kind = MTX_BOX;   norm_sel = 1'b0; end
                default: begin kind = MTX_NOISE; norm_sel = 1'b0; end
            endcase

            span = 0;
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                case (kind)
                    MTX_MIN:   mtx[k] = 64'h8000_8000_8000_8000;
                    MTX_MAX:   mtx[k] = 64'h7fff_7fff_7fff_7fff;
                    MTX_NOISE: mtx[k] = {$urandom, $urandom};
                    default:
                    begin
                        // near-diagonal matrix: a box whose size is offset over scale
                        for (int j = 0; j < 4; j++)
                            mtx[k][j*ENTRY_WIDTH +: ENTRY_WIDTH] =
                                16'($urandom_range(0, 64) - 32);
                        if (k < 3)
                        begin
                            diag[k] = $urandom_range(256, 8192);
                            mtx[k][k*ENTRY_WIDTH +: ENTRY_WIDTH] = 16'(diag[k]);
                        end
                    end
                endcase
            end
            if (kind == MTX_BOX)
            begin
                w = $urandom_range(0, 32767);
                mtx[3][3*ENTRY_WIDTH +: ENTRY_WIDTH] = 16'(w);
                dmin = diag[0];
                if (diag[1] < dmin)
                    dmin = diag[1];
                if (diag[2] < dmin)
                    dmin = diag[2];
                span = w / dmin + 4;
            end

            drain_block();
            if (phase == 3)
            begin
                send_idle_pct <= 62;
                recv_idle_pct <= 27;
            end
            else if (phase == 6)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            write_reg(REG_ROW0, mtx[0]);
            write_reg(REG_ROW1, mtx[1]);
            write_reg(REG_ROW2, mtx[2]);
            write_reg(REG_ROW3, mtx[3]);
            write_reg(REG_NORM, CFG_W'(norm_sel));
            cfg_we <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 4 && n == 80)
                    drain_block();
                offer_sphere(random_sphere(span), 1'b0, '0);
            end
        end

        drain_block();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("** frustum_sphere_cull: PASSED **");
        else
            $display("** frustum_sphere_cull: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/fsc_pkg.sv
src/fsc_dist.sv
src/fsc_cmp.sv
src/frustum_sphere_cull.sv
tb/sv/frustum_sphere_cull_tb.sv
